/* sv/scv_pkg.sv */
// Shared types and constants for the set-associative cache tag store with VI snooping.
package scv_pkg;

    localparam int MAX_SETS   = 256;
    localparam int MAX_WAYS   = 8;
    localparam int SET_W      = $clog2(MAX_SETS);
    localparam int WAY_W      = $clog2(MAX_WAYS);
    localparam int WAYS_W     = 4;
    localparam int TAG_W      = 32;
    localparam int ADDR_W     = 32;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD     = 2'd0,
        CMD_STORE    = 2'd1,
        CMD_LD_SNOOP = 2'd2,
        CMD_ST_SNOOP = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_WAYS   = 2'd1,
        CFG_OFFSET = 2'd2,
        CFG_INDEX  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             valid;
        logic             dirty;
    } way_entry_t;

    // One memory row holds a whole set and its replacement pointer
    typedef struct packed {
        way_entry_t [MAX_WAYS-1:0] ways;
        logic [WAY_W-1:0]          victim;
    } row_t;

    // Controller to datapath
    typedef struct packed {
        logic lookup;   // capture transaction, read set row
        logic commit;   // write back row, load result register
    } ctrl_cmd_t;

endpackage

/* sv/scv_if.sv */
// Channel interfaces: request, response and configuration write.
interface scv_req_if;
    logic                       valid;
    logic                       ready;
    logic [scv_pkg::CMD_W-1:0]  command;
    logic [scv_pkg::ADDR_W-1:0] address;

    modport source (output valid, output command, output address, input ready);
    modport sink   (input valid, input command, input address, output ready);
endinterface

interface scv_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic                      victim_dirty;
    logic [scv_pkg::WAY_W-1:0] way_used;
    logic [scv_pkg::SET_W-1:0] set_used;

    modport source (output valid, output hit, output victim_dirty, output way_used,
                    output set_used, input ready);
    modport sink   (input valid, input hit, input victim_dirty, input way_used,
                    input set_used, output ready);
endinterface

interface scv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [scv_pkg::CFG_IDX_W-1:0]  index;
    logic [scv_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/scv_ctrl.sv */
// Controller: sequences lookup and commit of one transaction and owns the response valid.
module scv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output scv_pkg::ctrl_cmd_t cmd
);
    import scv_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign req_ready  = (state_reg == S_IDLE);
    assign cmd.lookup = req_valid && (state_reg == S_IDLE);
    assign cmd.commit = (state_reg == S_UPDATE) && (!out_valid_reg || rsp_ready);
    assign rsp_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.lookup)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                // hold until the result register is free
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_lookup_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |=> state_reg == S_UPDATE)
        else $error("lookup not followed by update");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp_valid)
        else $error("commit did not present a result");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.lookup && cmd.commit))
        else $error("lookup and commit in the same cycle");

    a_stall_holds_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) && rsp_valid && !rsp_ready |=> state_reg == S_UPDATE)
        else $error("update left while result register blocked");

endmodule

/* sv/scv_datapath.sv */
// Datapath: configuration registers, set-row memory, way compare and row update.
module scv_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  scv_pkg::ctrl_cmd_t             cmd,
    input  logic                           cfg_we,
    input  logic [scv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scv_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [scv_pkg::CMD_W-1:0]      req_command,
    input  logic [scv_pkg::ADDR_W-1:0]     req_address,
    output logic                           hit,
    output logic                           victim_dirty,
    output logic [scv_pkg::WAY_W-1:0]      way_used,
    output logic [scv_pkg::SET_W-1:0]      set_used
);
    import scv_pkg::*;

    // Configuration
    logic              mode_reg;
    logic [WAYS_W-1:0] ways_reg;
    logic [3:0]        offset_reg;
    logic [3:0]        index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            ways_reg   <= 4'd1;
            offset_reg <= 4'd4;
            index_reg  <= 4'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_WAYS:   ways_reg   <= cfg_data;
                CFG_OFFSET: offset_reg <= cfg_data;
                CFG_INDEX:  index_reg  <= cfg_data;
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    // Address split; offset plus index never exceeds 30, so the tag shift stays in range
    logic [4:0]        shift;
    logic [ADDR_W-1:0] addr_sh;
    logic [SET_W-1:0]  imask;
    logic [SET_W-1:0]  set_calc;
    logic [TAG_W-1:0]  tag_calc;

    assign shift    = 5'(offset_reg) + 5'(index_reg);
    assign tag_calc = req_address >> shift;
    assign addr_sh  = req_address >> offset_reg;
    assign imask    = (index_reg >= 4'(SET_W)) ? '1
                    : SET_W'((9'd1 << index_reg) - 9'd1);
    assign set_calc = addr_sh[SET_W-1:0] & imask;

    // Captured transaction
    cmd_t             cmd_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [SET_W-1:0] set_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            cmd_reg <= cmd_t'(req_command);
            tag_reg <= tag_calc;
            set_reg <= set_calc;
        end
    end

    // Set-row memory; a row never written reads as all zero through its valid bit
    row_t mem [MAX_SETS];
    row_t rd_row_reg;
    row_t new_row;
    logic [MAX_SETS-1:0] row_ok_reg;
    logic                rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            rd_row_reg <= mem[set_calc];
        end
        if (cmd.commit)
        begin
            mem[set_reg] <= new_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.lookup)
            begin
                rd_ok_reg <= row_ok_reg[set_calc];
            end
            if (cmd.commit)
            begin
                row_ok_reg[set_reg] <= 1'b1;
            end
        end
    end

    // Way compare and update
    row_t              row;
    logic [WAYS_W-1:0] ways_eff;
    logic              found;
    logic [WAY_W-1:0]  a_way;
    logic [WAY_W-1:0]  v_way;
    logic [WAY_W-1:0]  t_way;
    logic              adv;
    logic              snoop;
    logic              store;
    logic              was_valid;
    logic              hit_c;
    logic              vd_c;
    logic [WAY_W-1:0]  way_c;

    assign row      = rd_ok_reg ? rd_row_reg : '0;
    assign ways_eff = (ways_reg == '0) ? WAYS_W'(1)
                    : (ways_reg > WAYS_W'(MAX_WAYS)) ? WAYS_W'(MAX_WAYS) : ways_reg;
    assign v_way    = row.victim;
    assign snoop    = (cmd_reg == CMD_LD_SNOOP) || (cmd_reg == CMD_ST_SNOOP);
    assign store    = (cmd_reg == CMD_STORE);

    always_comb
    begin
        found = 1'b0;
        a_way = '0;
        // lowest-numbered matching way wins: the scan runs from the top down and keeps the last match
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if ((WAYS_W'(w) < ways_eff) && (row.ways[w].tag == tag_reg))
            begin
                found = 1'b1;
                a_way = WAY_W'(w);
            end
        end
    end

    assign was_valid = row.ways[a_way].valid;

    always_comb
    begin
        new_row = row;
        hit_c   = 1'b0;
        vd_c    = 1'b0;
        way_c   = v_way;
        adv     = 1'b0;
        t_way   = v_way;

        if (found)
        begin
            if (snoop)
            begin
                vd_c = row.ways[v_way].dirty;
                if (!mode_reg)
                begin
                    hit_c = 1'b1;
                    way_c = a_way;
                end
                else
                begin
                    new_row.ways[a_way].valid = 1'b0;
                    if (was_valid)
                    begin
                        hit_c = 1'b1;
                        way_c = a_way;
                    end
                end
            end
            else if (!mode_reg || was_valid)
            begin
                hit_c = 1'b1;
                way_c = a_way;
                new_row.ways[a_way].valid = 1'b1;
                if (store)
                begin
                    new_row.ways[a_way].dirty = 1'b1;
                end
                adv   = 1'b1;
                t_way = a_way;
            end
            else
            begin
                // stale copy under VI: refill the victim way
                new_row.ways[v_way].tag   = tag_reg;
                new_row.ways[v_way].valid = 1'b1;
                if (store)
                begin
                    new_row.ways[v_way].dirty = 1'b1;
                end
                adv = 1'b1;
            end
        end
        else
        begin
            vd_c = row.ways[v_way].dirty;
            if (snoop)
            begin
                if (mode_reg)
                begin
                    new_row.ways[v_way].valid = 1'b0;
                end
            end
            else
            begin
                new_row.ways[v_way].tag   = tag_reg;
                new_row.ways[v_way].dirty = store;
                if (mode_reg)
                begin
                    new_row.ways[v_way].valid = 1'b1;
                end
                adv = 1'b1;
            end
        end

        // round-robin pointer, frozen with a single way
        if (adv && (ways_eff != WAYS_W'(1)))
        begin
            new_row.victim = ((WAYS_W'(t_way) + WAYS_W'(1)) < ways_eff) ? t_way + WAY_W'(1)
                           : '0;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit          <= hit_c;
            victim_dirty <= vd_c;
            way_used     <= way_c;
            set_used     <= set_reg;
        end
    end

endmodule

/* sv/set_assoc_cache_vi_snoop_unit.sv */
// Set-associative cache tag store with optional VI snooping: top level.
// Sequencing: a request is accepted in the idle state; its result is registered at commit in the
// update state and is offered from then on; a stalled result register holds it in the update state.
// A new request is accepted only after the previous one commits: its set row is read at accept
// and written back at commit, so transactions never overlap in the row memory.
// Reset: configuration returns to mode 0, one way, 4 offset bits, 4 index bits; all set
// rows read as zero through per-row valid bits, so no clearing pass is needed.
module set_assoc_cache_vi_snoop_unit (
    input logic    clk,
    input logic    rst_n,
    scv_req_if.sink   req,
    scv_rsp_if.source rsp,
    scv_cfg_if.sink   cfg
);
    import scv_pkg::*;

    ctrl_cmd_t cmd;

    assign cfg.ready = 1'b1;

    scv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    scv_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .req_command  (req.command),
        .req_address  (req.address),
        .hit          (rsp.hit),
        .victim_dirty (rsp.victim_dirty),
        .way_used     (rsp.way_used),
        .set_used     (rsp.set_used)
    );

endmodule
